// ===== design/erc_pkg.sv =====
// Package for the ellipse ray intersection core: widths, codes and channel types.
// No dependencies; every module of the block imports it.
package erc_pkg;

  localparam int DEF_COORD_FRAC_BITS = 16;
  localparam int DEF_COEF_FRAC_BITS  = 40;

  localparam int COORD_W      = 32;
  localparam int DIFF_W       = 33;
  localparam int SQ_W         = 64;
  localparam int XY_W         = 65;
  localparam int COEF_W       = 48;
  localparam int RAD_W        = 31;
  localparam int TERM_W       = 115;
  localparam int E_W          = 114;
  localparam int QUO_BITS     = 80;
  localparam int MAG_BITS     = 40;
  localparam int ROOT_REM_W   = MAG_BITS + 2;
  localparam int PP_W         = 58;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int STATUS_W     = 2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_AT_CENTER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_POS   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
  } query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] intersect_x;
    logic signed [COORD_W-1:0] intersect_y;
    logic [STATUS_W-1:0]       status;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COEF_W-1:0]  coef_xx;
    logic signed [COEF_W-1:0]  coef_yy;
    logic signed [COEF_W-1:0]  coef_xy;
    logic [RAD_W-1:0]          center_radius;
  } cfg_t;

  typedef struct packed {
    logic at_center;
    logic epos;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } side_t;

  typedef struct packed {
    logic [E_W-1:0]      rem;
    logic [QUO_BITS-1:0] nq;
  } div_lane_t;

  typedef struct packed {
    logic           valid;
    side_t          side;
    logic [E_W-1:0] e;
    div_lane_t      x;
    div_lane_t      y;
  } div_stage_t;

  typedef struct packed {
    logic [ROOT_REM_W-1:0] rem;
    logic [QUO_BITS-1:0]   qv;
    logic [MAG_BITS-1:0]   res;
  } root_lane_t;

  typedef struct packed {
    logic       valid;
    side_t      side;
    root_lane_t x;
    root_lane_t y;
  } root_stage_t;

endpackage

// ===== design/ellipse_ray_intersection_core.sv =====
// Top level: configuration registers, front pipeline, divider and root cell rows, output.
// Depends on erc_pkg, erc_front, erc_div_cell and erc_root_cell.
//
//   channel  signals                               direction
//   in       in_valid, in_ready, in_query          query transaction in
//   out      out_valid, out_ready, out_result      result transaction out
//   cfg      cfg_valid, cfg_ready, cfg_index/data  register write in
//
// One query enters per cycle unless stalled; it passes 5 front stages, 80 divider cells
// (one quotient bit each), 40 root cells (one root bit each) and the output register.
// All stages advance together; a result held at the output with out_ready low stalls
// the whole pipeline and in_ready. Synchronous reset clears the valid bits and loads
// the register defaults; writes are always taken.
module ellipse_ray_intersection_core import erc_pkg::*; #(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  query_t                in_query,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [RAD_W-1:0] RAD_RST = RAD_W'(((1 << COORD_FRAC_BITS) + 5) / 10);

  cfg_t cfg_r;
  logic adv;
  logic out_valid_r;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x      <= '0;
      cfg_r.center_y      <= '0;
      cfg_r.coef_xx       <= '0;
      cfg_r.coef_yy       <= '0;
      cfg_r.coef_xy       <= '0;
      cfg_r.center_radius <= RAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: cfg_r.center_x      <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: cfg_r.center_y      <= cfg_data[COORD_W-1:0];
        REG_COEF_XX:  cfg_r.coef_xx       <= cfg_data[COEF_W-1:0];
        REG_COEF_YY:  cfg_r.coef_yy       <= cfg_data[COEF_W-1:0];
        REG_COEF_XY:  cfg_r.coef_xy       <= cfg_data[COEF_W-1:0];
        REG_RADIUS:   cfg_r.center_radius <= cfg_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  div_stage_t  div_row [QUO_BITS+1];
  root_stage_t root_row [MAG_BITS+1];

  erc_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_query (in_query),
    .cfg      (cfg_r),
    .out_stage(div_row[0])
  );

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    erc_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .prev (div_row[i]),
      .cur  (div_row[i+1])
    );
  end

  always_comb begin
    root_row[0].valid = div_row[QUO_BITS].valid;
    root_row[0].side  = div_row[QUO_BITS].side;
    root_row[0].x.rem = '0;
    root_row[0].x.qv  = div_row[QUO_BITS].x.nq;
    root_row[0].x.res = '0;
    root_row[0].y.rem = '0;
    root_row[0].y.qv  = div_row[QUO_BITS].y.nq;
    root_row[0].y.res = '0;
  end

  for (genvar i = 0; i < MAG_BITS; i++) begin : g_root
    erc_root_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .prev (root_row[i]),
      .cur  (root_row[i+1])
    );
  end

  function automatic logic [COORD_W:0] place(input logic signed [COORD_W-1:0] c,
                                             input logic neg, input logic ovf,
                                             input logic [MAG_BITS-1:0] res);
    logic [MAG_BITS:0]                 mag;
    logic signed [MAG_BITS+2:0]        v;
    logic                              hi, lo;
    mag = ovf ? {1'b1, {MAG_BITS{1'b0}}} : {1'b0, res};
    v   = neg ? (MAG_BITS+3)'(c) - $signed({2'b00, mag})
              : (MAG_BITS+3)'(c) + $signed({2'b00, mag});
    hi  = !v[MAG_BITS+2] && (v[MAG_BITS+2:COORD_W-1] != '0);
    lo  = v[MAG_BITS+2] && (v[MAG_BITS+2:COORD_W-1] != '1);
    if (hi) begin
      return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end else if (lo) begin
      return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end
    return {1'b0, v[COORD_W-1:0]};
  endfunction

  root_stage_t       last;
  logic [COORD_W:0]  px_nxt, py_nxt;
  result_t           out_nxt, out_r;

  assign last = root_row[MAG_BITS];

  always_comb begin
    px_nxt = place(cfg_r.center_x, last.side.neg_x, last.side.ovf_x, last.x.res);
    py_nxt = place(cfg_r.center_y, last.side.neg_y, last.side.ovf_y, last.y.res);
    priority if (last.side.at_center) begin
      out_nxt.intersect_x = '0;
      out_nxt.intersect_y = '0;
      out_nxt.status      = ST_AT_CENTER;
    end else if (!last.side.epos) begin
      out_nxt.intersect_x = '0;
      out_nxt.intersect_y = '0;
      out_nxt.status      = ST_NOT_POS;
    end else begin
      out_nxt.intersect_x = px_nxt[COORD_W-1:0];
      out_nxt.intersect_y = py_nxt[COORD_W-1:0];
      out_nxt.status      = (px_nxt[COORD_W] || py_nxt[COORD_W]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

// ===== design/erc_front.sv =====
// Front pipeline: offsets, squares, centre test, quadratic form and divider setup.
// Depends on erc_pkg.
module erc_front import erc_pkg::*; #(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  query_t     in_query,
  input  cfg_t       cfg,
  output div_stage_t out_stage
);

  localparam int SHIFT  = 2 * COORD_FRAC_BITS + COEF_FRAC_BITS;
  localparam int NUM_W  = SQ_W + SHIFT;
  localparam int HEAD_W = NUM_W - QUO_BITS;

  function automatic logic signed [PP_W-1:0] mul_pp(input logic signed [24:0] a,
                                                    input logic signed [32:0] b);
    return a * b;
  endfunction

  function automatic logic signed [TERM_W-1:0] assemble(input logic signed [PP_W-1:0] hh,
                                                        input logic signed [PP_W-1:0] hl,
                                                        input logic signed [PP_W-1:0] lh,
                                                        input logic signed [PP_W-1:0] ll);
    return (TERM_W'(hh) <<< 56) + (TERM_W'(hl) <<< 24) + (TERM_W'(lh) <<< 32) + TERM_W'(ll);
  endfunction

  logic                     s1_valid_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= DIFF_W'(in_query.query_x) - DIFF_W'(cfg.center_x);
      dy_r <= DIFF_W'(in_query.query_y) - DIFF_W'(cfg.center_y);
    end
  end

  logic                    s2_valid_r;
  logic [SQ_W-1:0]         sqx_r, sqy_r;
  logic signed [XY_W-1:0]  pxy_r;
  logic [2*RAD_W-1:0]      r2_r;
  logic                    s2_negx_r, s2_negy_r;
  logic signed [2*DIFF_W-1:0] px2_nxt, py2_nxt, pxy_nxt;

  always_comb begin
    px2_nxt = dx_r * dx_r;
    py2_nxt = dy_r * dy_r;
    pxy_nxt = dx_r * dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r     <= px2_nxt[SQ_W-1:0];
      sqy_r     <= py2_nxt[SQ_W-1:0];
      pxy_r     <= pxy_nxt[XY_W-1:0];
      r2_r      <= cfg.center_radius * cfg.center_radius;
      s2_negx_r <= dx_r[DIFF_W-1];
      s2_negy_r <= dy_r[DIFF_W-1];
    end
  end

  logic                   s3_valid_r, s3_at_r, s3_negx_r, s3_negy_r;
  logic [SQ_W-1:0]        s3_sqx_r, s3_sqy_r;
  logic signed [PP_W-1:0] ppxx_r [4];
  logic signed [PP_W-1:0] ppyy_r [4];
  logic signed [PP_W-1:0] ppxy_r [4];
  logic [SQ_W:0]          dist_nxt;

  assign dist_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_at_r   <= dist_nxt < (SQ_W+1)'(r2_r);
      s3_negx_r <= s2_negx_r;
      s3_negy_r <= s2_negy_r;
      s3_sqx_r  <= sqx_r;
      s3_sqy_r  <= sqy_r;
      ppxx_r[0] <= mul_pp({cfg.coef_xx[47], cfg.coef_xx[47:24]}, {1'b0, sqx_r[63:32]});
      ppxx_r[1] <= mul_pp({cfg.coef_xx[47], cfg.coef_xx[47:24]}, {1'b0, sqx_r[31:0]});
      ppxx_r[2] <= mul_pp({1'b0, cfg.coef_xx[23:0]}, {1'b0, sqx_r[63:32]});
      ppxx_r[3] <= mul_pp({1'b0, cfg.coef_xx[23:0]}, {1'b0, sqx_r[31:0]});
      ppyy_r[0] <= mul_pp({cfg.coef_yy[47], cfg.coef_yy[47:24]}, {1'b0, sqy_r[63:32]});
      ppyy_r[1] <= mul_pp({cfg.coef_yy[47], cfg.coef_yy[47:24]}, {1'b0, sqy_r[31:0]});
      ppyy_r[2] <= mul_pp({1'b0, cfg.coef_yy[23:0]}, {1'b0, sqy_r[63:32]});
      ppyy_r[3] <= mul_pp({1'b0, cfg.coef_yy[23:0]}, {1'b0, sqy_r[31:0]});
      ppxy_r[0] <= mul_pp({cfg.coef_xy[47], cfg.coef_xy[47:24]}, pxy_r[64:32]);
      ppxy_r[1] <= mul_pp({cfg.coef_xy[47], cfg.coef_xy[47:24]}, {1'b0, pxy_r[31:0]});
      ppxy_r[2] <= mul_pp({1'b0, cfg.coef_xy[23:0]}, pxy_r[64:32]);
      ppxy_r[3] <= mul_pp({1'b0, cfg.coef_xy[23:0]}, {1'b0, pxy_r[31:0]});
    end
  end

  logic                     s4_valid_r, s4_at_r, s4_negx_r, s4_negy_r;
  logic [SQ_W-1:0]          s4_sqx_r, s4_sqy_r;
  logic signed [TERM_W-1:0] txx_r, tyy_r, txy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_at_r   <= s3_at_r;
      s4_negx_r <= s3_negx_r;
      s4_negy_r <= s3_negy_r;
      s4_sqx_r  <= s3_sqx_r;
      s4_sqy_r  <= s3_sqy_r;
      txx_r     <= assemble(ppxx_r[0], ppxx_r[1], ppxx_r[2], ppxx_r[3]);
      tyy_r     <= assemble(ppyy_r[0], ppyy_r[1], ppyy_r[2], ppyy_r[3]);
      txy_r     <= assemble(ppxy_r[0], ppxy_r[1], ppxy_r[2], ppxy_r[3]);
    end
  end

  logic signed [TERM_W-1:0] e_nxt;
  logic [NUM_W-1:0]         numx_nxt, numy_nxt;
  logic [E_W:0]             headx_nxt, heady_nxt;
  div_stage_t               stage_nxt, stage_r;

  always_comb begin
    e_nxt     = txx_r + (txy_r <<< 1) + tyy_r;
    numx_nxt  = {s4_sqx_r, {SHIFT{1'b0}}};
    numy_nxt  = {s4_sqy_r, {SHIFT{1'b0}}};
    headx_nxt = (E_W+1)'(numx_nxt[NUM_W-1 -: HEAD_W]);
    heady_nxt = (E_W+1)'(numy_nxt[NUM_W-1 -: HEAD_W]);
    stage_nxt.valid          = s4_valid_r;
    stage_nxt.e              = e_nxt[E_W-1:0];
    stage_nxt.side.at_center = s4_at_r;
    stage_nxt.side.epos      = !e_nxt[TERM_W-1] && (e_nxt != '0);
    stage_nxt.side.neg_x     = s4_negx_r;
    stage_nxt.side.neg_y     = s4_negy_r;
    stage_nxt.side.ovf_x     = headx_nxt >= {1'b0, e_nxt[E_W-1:0]};
    stage_nxt.side.ovf_y     = heady_nxt >= {1'b0, e_nxt[E_W-1:0]};
    stage_nxt.x.rem          = headx_nxt[E_W-1:0];
    stage_nxt.x.nq           = numx_nxt[QUO_BITS-1:0];
    stage_nxt.y.rem          = heady_nxt[E_W-1:0];
    stage_nxt.y.nq           = numy_nxt[QUO_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_stage = stage_r;

endmodule

// ===== design/erc_div_cell.sv =====
// One restoring division cell: one quotient bit for each coordinate lane.
// Depends on erc_pkg.
module erc_div_cell import erc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  div_stage_t prev,
  output div_stage_t cur
);

  function automatic div_lane_t div_step(input div_lane_t l, input logic [E_W-1:0] e);
    div_lane_t  o;
    logic [E_W:0] part;
    logic         ge;
    part  = {l.rem, l.nq[QUO_BITS-1]};
    ge    = part >= {1'b0, e};
    part  = ge ? part - {1'b0, e} : part;
    o.rem = part[E_W-1:0];
    o.nq  = {l.nq[QUO_BITS-2:0], ge};
    return o;
  endfunction

  div_stage_t cur_nxt, cur_r;

  always_comb begin
    cur_nxt   = prev;
    cur_nxt.x = div_step(prev.x, prev.e);
    cur_nxt.y = div_step(prev.y, prev.e);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else if (adv) begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

// ===== design/erc_root_cell.sv =====
// One square root cell: one root bit for each coordinate lane.
// Depends on erc_pkg.
module erc_root_cell import erc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  root_stage_t prev,
  output root_stage_t cur
);

  function automatic root_lane_t root_step(input root_lane_t l);
    root_lane_t            o;
    logic [ROOT_REM_W+1:0] part;
    logic [ROOT_REM_W+1:0] trial;
    logic                  ge;
    part  = {l.rem, l.qv[QUO_BITS-1 -: 2]};
    trial = (ROOT_REM_W+2)'({l.res, 2'b01});
    ge    = part >= trial;
    part  = ge ? part - trial : part;
    o.rem = part[ROOT_REM_W-1:0];
    o.qv  = {l.qv[QUO_BITS-3:0], 2'b00};
    o.res = {l.res[MAG_BITS-2:0], ge};
    return o;
  endfunction

  root_stage_t cur_nxt, cur_r;

  always_comb begin
    cur_nxt   = prev;
    cur_nxt.x = root_step(prev.x);
    cur_nxt.y = root_step(prev.y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else if (adv) begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule
